### design/cossim_pkg.sv
// Shared constants and status codes for the cosine similarity accumulator.
package cossim_pkg;

  // Default vector length limit and element width.
  localparam int MAX_LEN   = 1024;
  localparam int ELEM_BITS = 16;

  // Fixed field widths on the stream ports.
  localparam int IN_ELEM_W = 16;
  localparam int SIM_W     = 16;
  localparam int STATUS_W  = 2;

  // Number of fraction bits in the Q1.15 result.
  localparam int FRAC_BITS = 15;

  // Largest result magnitude.
  localparam logic [FRAC_BITS-1:0] SIM_MAX = '1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LEN  = 2'd2;

endpackage

### design/cosine_similarity_accumulator.sv
// Top level of the cosine similarity accumulator: sequencer, sums and stream ports.
//
// Each input transaction carries one pair of signed elements. A pair is accepted and
// then passes four steps in which one multiplier and one adder form and add a*a, a*b
// and b*b; a pair beyond MAX_LEN is dropped on acceptance. On a pair marked by tlast
// the block then computes trunc(dot * 2^15 / floor(sqrt(norm_a * norm_b))), saturated
// to +/-32767, in the same shared adder: NW multiply steps, NW square root steps, one
// compare and 15 divide steps, where NW = 2*ELEM_BITS - 1 + clog2(MAX_LEN) (41 at the
// defaults); a zero norm skips this work. The result sits in an output register, so
// the next vector may start loading while it waits.
// Status is 0 for a normal result, 1 for a zero norm (similarity 0) and 2 when
// pairs past MAX_LEN were dropped. The sums clear after each result.
module cosine_similarity_accumulator #(
  parameter int MAX_LEN   = cossim_pkg::MAX_LEN,
  parameter int ELEM_BITS = cossim_pkg::ELEM_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] elem_a, [31:16] elem_b
  input  logic        in_tlast,   // last
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] similarity
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int IW      = cossim_pkg::IN_ELEM_W;
  localparam int FB      = cossim_pkg::FRAC_BITS;
  localparam int SW      = cossim_pkg::SIM_W;
  localparam int PW      = 2 * ELEM_BITS;
  localparam int NW      = 2 * ELEM_BITS - 1 + $clog2(MAX_LEN);
  localparam int DW      = NW + 1;
  localparam int W       = NW + 2;
  localparam int CW      = $clog2(MAX_LEN + 1);
  localparam int STEP_W  = $clog2((NW > 16) ? NW : 16);

  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_M4, S_CHK, S_PMUL, S_SQRT, S_DCMP, S_DIV, S_OUT
  } state_t;

  state_t                       state_r, state_nxt;
  logic signed [ELEM_BITS-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic signed [ELEM_BITS-1:0]  a_in, b_in;
  logic                         last_r, last_nxt;
  logic [DW-1:0]                dot_r, dot_nxt;
  logic [NW-1:0]                na_r, na_nxt, nb_r, nb_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         exc_r, exc_nxt;
  logic                         zn_r, zn_nxt;
  logic [2*NW:0]                pr_r, pr_nxt;
  logic [NW-1:0]                rem_r, rem_nxt, root_r, root_nxt;
  logic [FB-1:0]                q_r, q_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [SW-1:0]                sim_r, sim_nxt;
  logic [cossim_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic signed [ELEM_BITS-1:0]  mul_x, mul_y;
  logic signed [PW-1:0]         prod;
  logic [W-1:0]                 prod_ext;
  logic [W-1:0]                 alu_a, alu_b;
  logic                         alu_sub;
  logic [W:0]                   alu_res;
  logic                         alu_ge;
  logic [DW-1:0]                dot_abs;
  logic [NW-1:0]                mag;
  logic                         neg;
  logic [SW-1:0]                q_ext;

  // Take the low ELEM_BITS bits of each 16-bit element field, or zero-extend the field when ELEM_BITS is wider.
  if (ELEM_BITS <= IW) begin : g_trunc
    assign a_in = in_tdata[ELEM_BITS-1:0];
    assign b_in = in_tdata[IW+ELEM_BITS-1:IW];
  end else begin : g_ext
    assign a_in = {{(ELEM_BITS-IW){1'b0}}, in_tdata[IW-1:0]};
    assign b_in = {{(ELEM_BITS-IW){1'b0}}, in_tdata[2*IW-1:IW]};
  end

  // Multiplier operand order: a*a, then a*b, then b*b.
  assign mul_x = (state_r == S_M3) ? b_r : a_r;
  assign mul_y = (state_r == S_M1) ? a_r : b_r;

  cossim_mul #(.EB(ELEM_BITS)) u_mul (
    .clk  (clk),
    .op_x (mul_x),
    .op_y (mul_y),
    .prod (prod)
  );

  assign prod_ext = {{(W-PW){prod[PW-1]}}, prod};

  // Magnitude and sign of the dot product for the divide.
  assign neg     = dot_r[DW-1];
  assign dot_abs = neg ? (~dot_r + DW'(1)) : dot_r;
  assign mag     = dot_abs[NW-1:0];

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_M2: begin
        alu_a = {{(W-NW){1'b0}}, na_r};
        alu_b = prod_ext;
      end
      S_M3: begin
        alu_a = {{(W-DW){dot_r[DW-1]}}, dot_r};
        alu_b = prod_ext;
      end
      S_M4: begin
        alu_a = {{(W-NW){1'b0}}, nb_r};
        alu_b = prod_ext;
      end
      S_PMUL: begin
        alu_a = {1'b0, pr_r[2*NW:NW]};
        alu_b = pr_r[0] ? {2'b00, na_r} : '0;
      end
      S_SQRT: begin
        alu_a   = {rem_r, pr_r[2*NW-1:2*NW-2]};
        alu_b   = {root_r, 2'b01};
        alu_sub = 1'b1;
      end
      S_DCMP: begin
        alu_a   = {2'b00, mag};
        alu_b   = {2'b00, root_r};
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = {1'b0, rem_r, 1'b0};
        alu_b   = {2'b00, root_r};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  cossim_alu #(.W(W)) u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .sub  (alu_sub),
    .res  (alu_res)
  );

  assign alu_ge = ~alu_res[W];
  assign q_ext  = {1'b0, q_r};

  // Sequencer next-state and datapath register updates.
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    last_nxt      = last_r;
    dot_nxt       = dot_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    cnt_nxt       = cnt_r;
    exc_nxt       = exc_r;
    zn_nxt        = zn_r;
    pr_nxt        = pr_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    sim_nxt       = sim_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;

    // The result register empties when its transaction completes.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          a_nxt    = a_in;
          b_nxt    = b_in;
          last_nxt = in_tlast;
          if (cnt_r < CW'(MAX_LEN)) begin
            state_nxt = S_M1;
          end else begin
            exc_nxt   = 1'b1;
            state_nxt = in_tlast ? S_CHK : S_IDLE;
          end
        end
      end
      S_M1: begin
        state_nxt = S_M2;
      end
      S_M2: begin
        na_nxt    = alu_res[NW-1:0];
        state_nxt = S_M3;
      end
      S_M3: begin
        dot_nxt   = alu_res[DW-1:0];
        state_nxt = S_M4;
      end
      S_M4: begin
        nb_nxt    = alu_res[NW-1:0];
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = last_r ? S_CHK : S_IDLE;
      end
      // Zero norm check, then load the norm product operands.
      S_CHK: begin
        if ((na_r == '0) || (nb_r == '0)) begin
          zn_nxt    = 1'b1;
          q_nxt     = '0;
          state_nxt = S_OUT;
        end else begin
          zn_nxt    = 1'b0;
          pr_nxt    = {{(NW+1){1'b0}}, nb_r};
          step_nxt  = '0;
          state_nxt = S_PMUL;
        end
      end
      // Shift-add multiply, one multiplier bit per cycle.
      S_PMUL: begin
        pr_nxt   = {1'b0, alu_res[NW:0], pr_r[NW-1:1]};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(NW - 1)) begin
          step_nxt  = '0;
          rem_nxt   = '0;
          root_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end
      // Restoring square root, one root bit per cycle.
      S_SQRT: begin
        pr_nxt   = pr_r << 2;
        rem_nxt  = alu_ge ? alu_res[NW-1:0] : alu_a[NW-1:0];
        root_nxt = {root_r[NW-2:0], alu_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(NW - 1)) begin
          state_nxt = S_DCMP;
        end
      end
      // A magnitude at or above the root saturates.
      S_DCMP: begin
        if (alu_ge) begin
          q_nxt     = cossim_pkg::SIM_MAX;
          state_nxt = S_OUT;
        end else begin
          rem_nxt   = mag;
          q_nxt     = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      // Restoring fraction divide, one quotient bit per cycle.
      S_DIV: begin
        rem_nxt  = alu_ge ? alu_res[NW-1:0] : alu_a[NW-1:0];
        q_nxt    = {q_r[FB-2:0], alu_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(FB - 1)) begin
          state_nxt = S_OUT;
        end
      end
      // Hand the result to the output register and clear the sums.
      S_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          sim_nxt       = neg ? (~q_ext + SW'(1)) : q_ext;
          if (exc_r) begin
            status_nxt = cossim_pkg::ST_LEN;
          end else if (zn_r) begin
            status_nxt = cossim_pkg::ST_ZERO;
          end else begin
            status_nxt = cossim_pkg::ST_OK;
          end
          dot_nxt   = '0;
          na_nxt    = '0;
          nb_nxt    = '0;
          cnt_nxt   = '0;
          exc_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, sums, working registers and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dot_r       <= '0;
      na_r        <= '0;
      nb_r        <= '0;
      cnt_r       <= '0;
      exc_r       <= 1'b0;
      zn_r        <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dot_r       <= dot_nxt;
      na_r        <= na_nxt;
      nb_r        <= nb_nxt;
      cnt_r       <= cnt_nxt;
      exc_r       <= exc_nxt;
      zn_r        <= zn_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    last_r   <= last_nxt;
    pr_r     <= pr_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    q_r      <= q_nxt;
    sim_r    <= sim_nxt;
    status_r <= status_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = sim_r;
  assign out_tuser  = status_r;

endmodule

### design/cossim_alu.sv
// Shared add/subtract unit used for accumulation, multiply, square root and divide.
module cossim_alu #(
  parameter int W = 43
) (
  input  logic [W-1:0] op_a,
  input  logic [W-1:0] op_b,
  input  logic         sub,
  output logic [W:0]   res
);

  // The top bit is the carry on add and the borrow on subtract.
  assign res = sub ? ({1'b0, op_a} - {1'b0, op_b}) : ({1'b0, op_a} + {1'b0, op_b});

endmodule

### design/cossim_mul.sv
// Registered signed element multiplier shared by the three products of a pair.
module cossim_mul #(
  parameter int EB = 16
) (
  input  logic                 clk,
  input  logic signed [EB-1:0] op_x,
  input  logic signed [EB-1:0] op_y,
  output logic signed [2*EB-1:0] prod
);

  logic signed [2*EB-1:0] prod_r;

  // One product per cycle, registered before it reaches the adder.
  always_ff @(posedge clk) begin
    prod_r <= op_x * op_y;
  end

  assign prod = prod_r;

endmodule

### tb/cosine_similarity_accumulator_checker.sv
// Scoreboard for the cosine similarity accumulator: predicts each result and checks it.
module cosine_similarity_accumulator_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] elem_a, [31:16] elem_b
  input  logic        in_tlast,   // last
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [15:0] similarity
  input  logic [1:0]  out_tuser,  // [1:0] status
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] sim;
    logic [1:0]  status;
  } cos_result_t;

  // Running sums of the vector being loaded.
  logic signed [63:0] dot_acc;
  logic signed [63:0] norm_a_acc;
  logic signed [63:0] norm_b_acc;
  int unsigned        pair_cnt;
  logic               overflowed;

  cos_result_t sim_expected_q[$];
  cos_result_t head;
  int          mismatches = 0;

  // Integer square root of a 128-bit value, one result bit per step.
  function automatic logic [63:0] root_floor(input logic [127:0] n);
    logic [63:0]  root;
    logic [63:0]  cand;
    logic [127:0] sq;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      sq   = {64'd0, cand} * {64'd0, cand};
      if (sq <= n) root = cand;
    end
    return root;
  endfunction

  task automatic clear_sums();
    dot_acc    = '0;
    norm_a_acc = '0;
    norm_b_acc = '0;
    pair_cnt   = 0;
    overflowed = 1'b0;
  endtask

  // Adds one pair; on the last pair of a vector, queues the similarity it produces.
  task automatic accumulate_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                                 input logic lst);
    cos_result_t  res;
    logic [127:0] prod;
    logic [127:0] quot;
    logic [63:0]  den;
    logic [63:0]  mag;
    logic [15:0]  q;
    logic         neg;
    if (pair_cnt < cossim_pkg::MAX_LEN) begin
      dot_acc    = dot_acc + a * b;
      norm_a_acc = norm_a_acc + a * a;
      norm_b_acc = norm_b_acc + b * b;
      pair_cnt++;
    end else begin
      overflowed = 1'b1;
    end
    if (lst) begin
      res.sim    = '0;
      res.status = cossim_pkg::ST_OK;
      if (norm_a_acc == 0 || norm_b_acc == 0) begin
        res.status = cossim_pkg::ST_ZERO;
      end else begin
        prod = {64'd0, norm_a_acc} * {64'd0, norm_b_acc};
        den  = root_floor(prod);
        neg  = dot_acc[63];
        mag  = neg ? -dot_acc : dot_acc;
        // A magnitude at or above the root saturates.
        if (mag >= den) begin
          q = {1'b0, cossim_pkg::SIM_MAX};
        end else begin
          quot = ({64'd0, mag} << cossim_pkg::FRAC_BITS) / {64'd0, den};
          q    = quot[15:0];
        end
        res.sim = neg ? -q : q;
      end
      // Dropped pairs override the status.
      if (overflowed) res.status = cossim_pkg::ST_LEN;
      sim_expected_q.push_back(res);
      clear_sums();
    end
  endtask

  // Watch both channels at each clock edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_sums();
      sim_expected_q.delete();
    end else begin
      // Result transaction: compare with the oldest expectation.
      if (out_tvalid && out_tready) begin
        if (sim_expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual similarity %0d status %0d",
                   $time, $signed(out_tdata), out_tuser);
          mismatches++;
        end else begin
          head = sim_expected_q.pop_front();
          if (out_tdata !== head.sim) begin
            $display("%0t: similarity mismatch, expected %0d, actual %0d", $time,
                     $signed(head.sim), $signed(out_tdata));
            mismatches++;
          end
          if (out_tuser !== head.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     head.status, out_tuser);
            mismatches++;
          end
        end
      end
      // Input transaction: update the sums.
      if (in_tvalid && in_tready) begin
        accumulate_pair(in_tdata[15:0], in_tdata[31:16], in_tlast);
      end
    end
    fail_count  <= mismatches;
    outstanding <= sim_expected_q.size();
  end

endmodule

### tb/cosine_similarity_accumulator_tb.sv
// Testbench top for the cosine similarity accumulator: clock, reset, stimulus and verdict.
module cosine_similarity_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 550;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 2000000;

  typedef enum {RX_FREE, RX_RANDOM, RX_SPARSE} rx_mode_t;
  typedef enum {
    SHAPE_UNIFORM, SHAPE_SAME, SHAPE_NEGATED, SHAPE_NEAR, SHAPE_ZERO_A, SHAPE_ZERO_B
  } vec_shape_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] elem_a, [31:16] elem_b
  logic        in_tlast;   // last
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] similarity
  logic [1:0]  out_tuser;  // [1:0] status

  int   fail_count;
  int   outstanding;
  int   cycle_count   = 0;
  int   burst_left    = 0;
  logic hold_off_req  = 1'b0;
  logic hold_off_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cosine_similarity_accumulator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  cosine_similarity_accumulator_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Element values weighted toward the extremes, zero and small magnitudes.
  function automatic logic [15:0] rand_elem();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0:       v = 16'h8000;
      1:       v = 16'h7FFF;
      2:       v = 16'h0000;
      3:       v = 16'($urandom_range(0, 8)) - 16'd4;
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  // Offer one pair and wait for its transaction; gaps fall between bursts.
  task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // Stop sending until every predicted result has been taken.
  task automatic wait_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Receiver: random stretches of free flow, coin flips and sparse acceptance,
  // with one long hold-off when the stimulus asks for it.
  initial begin : receiver
    int       stretch;
    rx_mode_t mode;
    logic     rdy;
    out_tready = 1'b0;
    stretch    = 0;
    mode       = RX_FREE;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end
      if (stretch == 0) begin
        case ($urandom_range(0, 2))
          0:       mode = RX_FREE;
          1:       mode = RX_RANDOM;
          default: mode = RX_SPARSE;
        endcase
        stretch = $urandom_range(5, 200);
      end
      stretch--;
      case (mode)
        RX_FREE:   rdy = 1'b1;
        RX_RANDOM: rdy = 1'($urandom_range(0, 1));
        default:   rdy = ($urandom_range(0, 7) == 0);
      endcase
      out_tready <= rdy;
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int          len;
    int          sent;
    vec_shape_t  shape;
    logic [15:0] a;
    logic [15:0] b;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: saturation both ways, zero norms, orthogonal and mixed vectors.
    send_pair(16'h7FFF, 16'h7FFF, 1'b1);
    send_pair(16'h8000, 16'h7FFF, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'h0000, 16'h1234, 1'b1);
    send_pair(16'h4321, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'h03E8, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h03E8, 1'b1);
    send_pair(16'h0064, 16'h00C8, 1'b0);
    send_pair(16'hFED4, 16'h0032, 1'b0);
    send_pair(16'h04D2, 16'hFC19, 1'b1);
    send_pair(16'h0001, 16'h7FFF, 1'b0);
    send_pair(16'h7FFF, 16'h0001, 1'b1);
    send_pair(16'h5555, 16'hAAAA, 1'b1);
    send_pair(16'hAAAA, 16'h5555, 1'b0);
    send_pair(16'hFFFF, 16'h0001, 1'b1);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    wait_results();

    // Long receiver hold-off while short vectors keep coming, so the input stalls.
    hold_off_req = 1'b1;
    repeat (59) send_pair(rand_elem(), rand_elem(), 1'($urandom_range(0, 1)));
    send_pair(rand_elem(), rand_elem(), 1'b1);
    wait_results();

    // Length limit: a vector one to three pairs past MAX_LEN, so its last pairs are dropped.
    len = cossim_pkg::MAX_LEN + $urandom_range(1, 3);
    for (int i = 0; i < len; i++) send_pair(rand_elem(), rand_elem(), i == len - 1);
    wait_results();

    // Random vectors, mostly short, of several shapes.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0:       shape = SHAPE_SAME;
        1:       shape = SHAPE_NEGATED;
        2:       shape = SHAPE_NEAR;
        3:       shape = SHAPE_ZERO_A;
        4:       shape = SHAPE_ZERO_B;
        default: shape = SHAPE_UNIFORM;
      endcase
      for (int i = 0; i < len; i++) begin
        a = rand_elem();
        b = rand_elem();
        case (shape)
          SHAPE_SAME:    b = a;
          SHAPE_NEGATED: b = -a;
          SHAPE_NEAR:    b = a + 16'($urandom_range(0, 6)) - 16'd3;
          SHAPE_ZERO_A:  a = 16'h0000;
          SHAPE_ZERO_B:  b = 16'h0000;
          default:       ;
        endcase
        send_pair(a, b, i == len - 1);
        sent++;
      end
    end

    // Drain, let the block settle, then give the verdict.
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
design/cossim_pkg.sv
design/cossim_alu.sv
design/cossim_mul.sv
design/cosine_similarity_accumulator.sv
tb/cosine_similarity_accumulator_checker.sv
tb/cosine_similarity_accumulator_tb.sv
